@@ rtl/core/assert_macros.svh @@
// assert_macros.svh: assertion shorthands for the tile decode cache RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PTDC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PTDC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/ptdc_pkg.sv @@
// ptdc_pkg: codes, sizes and types of the planar tile decode cache
package ptdc_pkg;

   // transaction modes
   localparam logic [1:0] MODE_INVAL = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // depth codes
   localparam logic [1:0] DEPTH_2BPP = 2'd0;
   localparam logic [1:0] DEPTH_4BPP = 2'd1;
   localparam logic [1:0] DEPTH_8BPP = 2'd2;
   localparam logic [1:0] DEPTH_BAD  = 2'd3;

   // valid bitmap, eight flags per byte, placed above video memory
   localparam int         VALID_BYTES = 896;
   localparam logic [9:0] VOFF_4BPP   = 10'd512;
   localparam logic [9:0] VOFF_8BPP   = 10'd768;

   // decoded store: 64-bit words, 4/2/1 rows per word for 2/4/8 bpp
   localparam int          DEC_WORDS     = 24576;
   localparam int          DEC_AW        = 15;
   localparam logic [14:0] DEC_BASE_4BPP = 15'd8192;
   localparam logic [14:0] DEC_BASE_8BPP = 15'd16384;

   // one byte per bitplane of a tile row
   typedef logic [7:0][7:0] plane_set_type;

   // tag travelling with each video memory fetch
   typedef struct packed {
      logic       vld;
      logic [2:0] plane;
      logic [2:0] row;
      logic       row_end;
   } fetch_tag_type;

endpackage

@@ rtl/core/planar_tile_decode_cache_unit.sv @@
// planar_tile_decode_cache_unit: video memory copy with a decoded planar tile cache.
// Request channel (req_*): valid/ready; one transaction per item. Mode invalidate
// clears every valid flag, mode write stores req_write_byte at req_address (wrapped
// to VRAM_BYTES), mode read returns the eight rows of tile req_tile_index at depth
// req_depth_sel on the response channel (rsp_*), row 0 first, last_row on row 7.
// An unknown depth gives one response with rsp_bad_depth and rsp_last_row set.
// Writes never touch the cache, so a hit may return rows decoded from older data.
// req_ready is high only while the sequencer is idle. A write is stored without
// leaving the idle state. An invalidate sweeps the 896-byte valid bitmap. A read
// miss adds a fetch of 8*planes bytes from video memory, as the single video
// memory read port gives one byte per cycle.
// Reset (synchronous, active high) starts a clearing pass over video memory and
// the valid bitmap, during which no request is taken.
// Responses sit in an output register; a stalled receiver holds the row there and
// the row sequencer waits, without losing or repeating a row.
`include "assert_macros.svh"

module planar_tile_decode_cache_unit #(
   parameter int VRAM_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_byte,
   input  logic [1:0]  req_depth_sel,
   input  logic [11:0] req_tile_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_row_pixels,
   output logic [2:0]  rsp_row_number,
   output logic        rsp_was_hit,
   output logic        rsp_bad_depth,
   output logic        rsp_last_row
);

   localparam int VA_W       = $clog2(VRAM_BYTES);
   localparam int M0_DEPTH   = VRAM_BYTES + ptdc_pkg::VALID_BYTES;
   localparam int M0_W       = $clog2(M0_DEPTH);
   localparam int WRAP_STEPS = 6;   // quotient of a 16-bit address stays below 64
   localparam int WRAP_W     = 16 + WRAP_STEPS;

   // sequencer states
   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_INVAL  = 4'd2;
   localparam logic [3:0] ST_ERROR  = 4'd3;
   localparam logic [3:0] ST_LOOKUP = 4'd4;
   localparam logic [3:0] ST_VTEST  = 4'd5;
   localparam logic [3:0] ST_FETCH  = 4'd6;
   localparam logic [3:0] ST_OISSUE = 4'd7;
   localparam logic [3:0] ST_OHOLD  = 4'd8;

   // address modulo VRAM_BYTES by restoring subtraction
   function automatic logic [VA_W-1:0] vram_wrap(input logic [15:0] addr);
      logic [WRAP_W-1:0] rem;
      logic [WRAP_W-1:0] lim;
      rem = WRAP_W'(addr);
      for (int i = WRAP_STEPS - 1; i >= 0; i--) begin
         lim = WRAP_W'(VRAM_BYTES) << i;
         if (rem >= lim) begin
            rem = rem - lim;
         end
      end
      return rem[VA_W-1:0];
   endfunction

   // decoded store word holding a given row of a tile
   function automatic logic [ptdc_pkg::DEC_AW-1:0] dec_addr(input logic [1:0]  depth,
                                                            input logic [11:0] tile,
                                                            input logic [2:0]  row);
      logic [ptdc_pkg::DEC_AW-1:0] a;
      case (depth)
         ptdc_pkg::DEPTH_2BPP: a = {2'b00, tile, row[2]};
         ptdc_pkg::DEPTH_4BPP: a = ptdc_pkg::DEC_BASE_4BPP + {2'b00, tile[10:0], row[2:1]};
         default:              a = ptdc_pkg::DEC_BASE_8BPP + {2'b00, tile[9:0], row};
      endcase
      return a;
   endfunction

   logic [3:0]                  state_ff, state_in;
   logic [M0_W-1:0]             sweep_ff, sweep_in;
   logic [1:0]                  depth_ff, depth_in;
   logic [11:0]                 tile_ff, tile_in;
   logic                        hit_ff, hit_in;
   logic [2:0]                  fy_ff, fy_in;
   logic [2:0]                  fk_ff, fk_in;
   logic                        issue_done_ff, issue_done_in;
   logic [15:0]                 raw_ff, raw_in;
   ptdc_pkg::fetch_tag_type     tag_a_ff, tag_a_in;
   ptdc_pkg::fetch_tag_type     tag_b_ff;
   ptdc_pkg::plane_set_type     plane_ff;
   logic                        row_ready_ff;
   logic [2:0]                  row_num_ff;
   logic [63:0]                 acc_ff, acc_in;
   logic [2:0]                  out_y_ff, out_y_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [63:0]                 rsp_pix_ff, rsp_pix_in;
   logic [2:0]                  rsp_row_ff, rsp_row_in;
   logic                        rsp_hit_ff, rsp_hit_in;
   logic                        rsp_bad_ff, rsp_bad_in;
   logic                        rsp_last_ff, rsp_last_in;

   // video memory with the valid bitmap above it
   logic [7:0]                  vram_mem [M0_DEPTH];
   logic [7:0]                  rd0_ff;
   logic [M0_W-1:0]             rd0_addr;
   logic                        we0;
   logic [M0_W-1:0]             wa0;
   logic [7:0]                  wd0;

   // decoded row store
   logic [63:0]                 dec_mem [ptdc_pkg::DEC_WORDS];
   logic [63:0]                 dec_rd_ff;
   logic                        dec_re;
   logic [ptdc_pkg::DEC_AW-1:0] dec_raddr;
   logic                        dec_we;
   logic [ptdc_pkg::DEC_AW-1:0] dec_waddr;

   logic                        slot_free;
   logic [2:0]                  planes_m1;
   logic [9:0]                  valid_off;
   logic [M0_W-1:0]             valid_addr;
   logic [7:0]                  valid_mask;
   logic [15:0]                 tile_base;
   logic [63:0]                 packed_row;
   logic                        word_full;
   logic [15:0]                 sel16;
   logic [31:0]                 sel32;
   logic [63:0]                 out_pix;
   logic [11:0]                 req_tile_masked;

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_pixels = rsp_pix_ff;
   assign rsp_row_number = rsp_row_ff;
   assign rsp_was_hit    = rsp_hit_ff;
   assign rsp_bad_depth  = rsp_bad_ff;
   assign rsp_last_row   = rsp_last_ff;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // per-depth geometry of the held tile
   always_comb begin
      case (depth_ff)
         ptdc_pkg::DEPTH_2BPP: begin
            planes_m1 = 3'd1;
            valid_off = {1'b0, tile_ff[11:3]};
            tile_base = {tile_ff, 4'b0000};
         end
         ptdc_pkg::DEPTH_4BPP: begin
            planes_m1 = 3'd3;
            valid_off = ptdc_pkg::VOFF_4BPP + {2'b00, tile_ff[10:3]};
            tile_base = {tile_ff[10:0], 5'b00000};
         end
         default: begin
            planes_m1 = 3'd7;
            valid_off = ptdc_pkg::VOFF_8BPP + {3'b000, tile_ff[9:3]};
            tile_base = {tile_ff[9:0], 6'b000000};
         end
      endcase
   end

   assign valid_addr = M0_W'(VRAM_BYTES) + M0_W'(valid_off);
   assign valid_mask = 8'b0000_0001 << tile_ff[2:0];

   // tile number modulo the tile count of the requested depth
   always_comb begin
      case (req_depth_sel)
         ptdc_pkg::DEPTH_2BPP: req_tile_masked = req_tile_index;
         ptdc_pkg::DEPTH_4BPP: req_tile_masked = {1'b0, req_tile_index[10:0]};
         default:              req_tile_masked = {2'b00, req_tile_index[9:0]};
      endcase
   end

   // row decode and packing of rows into store words
   ptdc_row_decode u_row_decode (
      .depth_sel   (depth_ff),
      .plane_bytes (plane_ff),
      .packed_row  (packed_row)
   );

   always_comb begin
      acc_in    = acc_ff;
      word_full = 1'b1;
      case (depth_ff)
         ptdc_pkg::DEPTH_2BPP: begin
            acc_in[{row_num_ff[1:0], 4'b0000} +: 16] = packed_row[15:0];
            word_full = (row_num_ff[1:0] == 2'b11);
         end
         ptdc_pkg::DEPTH_4BPP: begin
            acc_in[{row_num_ff[0], 5'b00000} +: 32] = packed_row[31:0];
            word_full = row_num_ff[0];
         end
         default: begin
            acc_in    = packed_row;
            word_full = 1'b1;
         end
      endcase
   end

   assign dec_we    = row_ready_ff && word_full;
   assign dec_waddr = dec_addr(depth_ff, tile_ff, row_num_ff);

   // row extraction from the store word held for out_y_ff
   assign sel16 = dec_rd_ff[{out_y_ff[1:0], 4'b0000} +: 16];
   assign sel32 = dec_rd_ff[{out_y_ff[0], 5'b00000} +: 32];

   always_comb begin
      out_pix = '0;
      case (depth_ff)
         ptdc_pkg::DEPTH_2BPP: begin
            for (int x = 0; x < 8; x++) begin
               out_pix[x*8 +: 8] = {6'b000000, sel16[x*2 +: 2]};
            end
         end
         ptdc_pkg::DEPTH_4BPP: begin
            for (int x = 0; x < 8; x++) begin
               out_pix[x*8 +: 8] = {4'b0000, sel32[x*4 +: 4]};
            end
         end
         default: begin
            out_pix = dec_rd_ff;
         end
      endcase
   end

   // video memory ports
   assign rd0_addr = (state_ff == ST_LOOKUP) ? valid_addr : M0_W'(vram_wrap(raw_ff));

   always_comb begin
      we0 = 1'b0;
      wa0 = sweep_ff;
      wd0 = 8'h00;
      case (state_ff)
         ST_CLEAR, ST_INVAL: begin
            we0 = 1'b1;
         end
         ST_IDLE: begin
            we0 = req_valid && (req_mode == ptdc_pkg::MODE_WRITE);
            wa0 = M0_W'(vram_wrap(req_address));
            wd0 = req_write_byte;
         end
         ST_VTEST: begin
            we0 = !rd0_ff[tile_ff[2:0]];
            wa0 = valid_addr;
            wd0 = rd0_ff | valid_mask;
         end
         default: begin
            we0 = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      depth_in      = depth_ff;
      tile_in       = tile_ff;
      hit_in        = hit_ff;
      fy_in         = fy_ff;
      fk_in         = fk_ff;
      issue_done_in = issue_done_ff;
      raw_in        = raw_ff;
      out_y_in      = out_y_ff;
      dec_re        = 1'b0;
      dec_raddr     = dec_addr(depth_ff, tile_ff, out_y_ff);

      tag_a_in.vld     = 1'b0;
      tag_a_in.plane   = fk_ff;
      tag_a_in.row     = fy_ff;
      tag_a_in.row_end = (fk_ff == planes_m1);

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pix_in   = rsp_pix_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_CLEAR, ST_INVAL: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == M0_W'(M0_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  ptdc_pkg::MODE_INVAL: begin
                     sweep_in = M0_W'(VRAM_BYTES);
                     state_in = ST_INVAL;
                  end
                  ptdc_pkg::MODE_READ: begin
                     depth_in = req_depth_sel;
                     tile_in  = req_tile_masked;
                     state_in = (req_depth_sel == ptdc_pkg::DEPTH_BAD) ? ST_ERROR
                                                                       : ST_LOOKUP;
                  end
                  default: begin
                     state_in = ST_IDLE;   // writes go straight to memory
                  end
               endcase
            end
         end
         ST_ERROR: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = '0;
               rsp_row_in   = 3'd0;
               rsp_hit_in   = 1'b0;
               rsp_bad_in   = 1'b1;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_LOOKUP: begin
            out_y_in = 3'd0;
            state_in = ST_VTEST;
         end
         ST_VTEST: begin
            hit_in        = rd0_ff[tile_ff[2:0]];
            fy_in         = 3'd0;
            fk_in         = 3'd0;
            issue_done_in = 1'b0;
            state_in      = rd0_ff[tile_ff[2:0]] ? ST_OISSUE : ST_FETCH;
         end
         ST_FETCH: begin
            if (!issue_done_ff) begin
               tag_a_in.vld = 1'b1;
               raw_in       = tile_base | {10'd0, fk_ff[2:1], fy_ff, fk_ff[0]};
               if (fk_ff == planes_m1) begin
                  fk_in = 3'd0;
                  fy_in = fy_ff + 3'd1;
                  if (fy_ff == 3'd7) begin
                     issue_done_in = 1'b1;
                  end
               end else begin
                  fk_in = fk_ff + 3'd1;
               end
            end
            if (row_ready_ff && (row_num_ff == 3'd7)) begin
               state_in = ST_OISSUE;
            end
         end
         ST_OISSUE: begin
            dec_re   = 1'b1;
            state_in = ST_OHOLD;
         end
         ST_OHOLD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = out_pix;
               rsp_row_in   = out_y_ff;
               rsp_hit_in   = hit_ff;
               rsp_bad_in   = 1'b0;
               rsp_last_in  = (out_y_ff == 3'd7);
               if (out_y_ff == 3'd7) begin
                  state_in = ST_IDLE;
               end else begin
                  // fetch the next row while this one is shown
                  out_y_in  = out_y_ff + 3'd1;
                  dec_re    = 1'b1;
                  dec_raddr = dec_addr(depth_ff, tile_ff, out_y_ff + 3'd1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         sweep_ff      <= '0;
         hit_ff        <= 1'b0;
         fy_ff         <= 3'd0;
         fk_ff         <= 3'd0;
         issue_done_ff <= 1'b1;
         out_y_ff      <= 3'd0;
         tag_a_ff      <= '0;
         tag_b_ff      <= '0;
         row_ready_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         hit_ff        <= hit_in;
         fy_ff         <= fy_in;
         fk_ff         <= fk_in;
         issue_done_ff <= issue_done_in;
         out_y_ff      <= out_y_in;
         tag_a_ff      <= tag_a_in;
         tag_b_ff      <= tag_a_ff;
         row_ready_ff  <= tag_b_ff.vld && tag_b_ff.row_end;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      depth_ff    <= depth_in;
      tile_ff     <= tile_in;
      raw_ff      <= raw_in;
      row_num_ff  <= tag_b_ff.row;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_bad_ff  <= rsp_bad_in;
      rsp_last_ff <= rsp_last_in;
      if (tag_b_ff.vld) begin
         plane_ff[tag_b_ff.plane] <= rd0_ff;
      end
      if (row_ready_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we0) begin
         vram_mem[wa0] <= wd0;
      end
      rd0_ff <= vram_mem[rd0_addr];
   end

   always_ff @(posedge clock) begin
      if (dec_we) begin
         dec_mem[dec_waddr] <= acc_in;
      end
      if (dec_re) begin
         dec_rd_ff <= dec_mem[dec_raddr];
      end
   end

   `PTDC_ASSERT_SAME(a_err_single, clock, reset, rsp_valid && rsp_bad_depth, rsp_last_row && (rsp_row_number == 3'd0), "bad depth response is not a lone row 0")
   `PTDC_ASSERT_NEXT(a_row_order, clock, reset, rsp_valid && rsp_ready && !rsp_last_row, rsp_valid && (rsp_row_number == $past(rsp_row_number) + 3'd1), "row sequence broken")
   `PTDC_ASSERT_NEXT(a_hit_steady, clock, reset, rsp_valid && rsp_ready && !rsp_last_row, rsp_was_hit == $past(rsp_was_hit), "hit flag changed within a tile")
   `PTDC_ASSERT_SAME(a_decode_in_fetch, clock, reset, row_ready_ff, state_ff == ST_FETCH, "decoded row outside fetch")
   `PTDC_ASSERT_SAME(a_clear_quiet, clock, reset, state_ff == ST_CLEAR, !rsp_valid_ff, "response during clearing pass")

endmodule

@@ rtl/core/ptdc_row_decode.sv @@
// ptdc_row_decode: bitplane bytes of one tile row to packed colour indices
module ptdc_row_decode (
   input  logic [1:0]              depth_sel,
   input  ptdc_pkg::plane_set_type plane_bytes,
   output logic [63:0]             packed_row
);

   // pixel x sits at bits x*planes upward; leftmost pixel is bit 7 of each plane
   always_comb begin
      packed_row = '0;
      case (depth_sel)
         ptdc_pkg::DEPTH_2BPP: begin
            for (int x = 0; x < 8; x++) begin
               for (int k = 0; k < 2; k++) begin
                  packed_row[x*2+k] = plane_bytes[k][7-x];
               end
            end
         end
         ptdc_pkg::DEPTH_4BPP: begin
            for (int x = 0; x < 8; x++) begin
               for (int k = 0; k < 4; k++) begin
                  packed_row[x*4+k] = plane_bytes[k][7-x];
               end
            end
         end
         ptdc_pkg::DEPTH_8BPP: begin
            for (int x = 0; x < 8; x++) begin
               for (int k = 0; k < 8; k++) begin
                  packed_row[x*8+k] = plane_bytes[k][7-x];
               end
            end
         end
         default: begin
            packed_row = '0;
         end
      endcase
   end

endmodule
